/* sv/falru_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// falru_pkg
// Shared widths, defaults, register indexes and the result record of the
// fully associative LRU cache directory.
// ----------------------------------------------------------------------------
package falru_pkg;

   localparam int LINES_DEF     = 16;
   localparam int ADDR_BITS_DEF = 32;

   localparam int REQ_ADDR_W = 32;
   localparam int LINE_IDX_W = 4;
   localparam int LINE_BASE_W = 32;
   localparam int BOFF_W     = 10;
   localparam int STAMP_W    = 32;

   localparam int OB_W       = 4;
   localparam int AL_W       = 5;
   localparam int CSR_DATA_W = 5;
   localparam int CSR_IDX_W  = 1;

   localparam logic [OB_W-1:0] MIN_OB   = 4'd5;
   localparam logic [OB_W-1:0] MAX_OB   = 4'd10;
   localparam logic [OB_W-1:0] OB_RESET = 4'd5;
   localparam logic [AL_W-1:0] AL_RESET = 5'd16;
   localparam int              READ_BYTES = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_LINE_OFFSET_BITS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_LINES     = 1'd1;

   typedef struct packed {
      logic                   hit;
      logic [LINE_IDX_W-1:0]  line_index;
      logic                   fill_needed;
      logic [LINE_BASE_W-1:0] line_base;
      logic [BOFF_W-1:0]      byte_offset;
      logic                   last;
   } result_type;

endpackage
`default_nettype wire

/* sv/falru_req_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// falru_req_if
// Request channel: one read address per beat.
// ----------------------------------------------------------------------------
interface falru_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [falru_pkg::REQ_ADDR_W-1:0]     read_address;

   modport source (output valid, output read_address, input ready);
   modport sink   (input valid, input read_address, output ready);
endinterface
`default_nettype wire

/* sv/falru_rsp_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// falru_rsp_if
// Response channel: one directory result per beat.
// ----------------------------------------------------------------------------
interface falru_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 hit;
   logic [falru_pkg::LINE_IDX_W-1:0]     line_index;
   logic                                 fill_needed;
   logic [falru_pkg::LINE_BASE_W-1:0]    line_base;
   logic [falru_pkg::BOFF_W-1:0]         byte_offset;
   logic                                 last;

   modport source (output valid, output hit, output line_index, output fill_needed,
                   output line_base, output byte_offset, output last, input ready);
   modport sink   (input valid, input hit, input line_index, input fill_needed,
                   input line_base, input byte_offset, input last, output ready);
endinterface
`default_nettype wire

/* sv/falru_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// falru_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered.
// ----------------------------------------------------------------------------
module falru_ram #(
   parameter int WIDTH = falru_pkg::STAMP_W,
   parameter int DEPTH = falru_pkg::LINES_DEF
) (
   input  wire logic                                            clock,
   input  wire logic                                            we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    waddr,
   input  wire logic [WIDTH-1:0]                                wdata,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    raddr,
   output logic      [WIDTH-1:0]                                rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

/* sv/falru_out.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// falru_out
// Output register: holds one finished result until the response beat is
// taken, so the lookup engine can move on to the next request.
// ----------------------------------------------------------------------------
module falru_out (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  res_we,
   input  wire falru_pkg::result_type res,
   output logic                       out_free,
   falru_rsp_if.source                rsp_bus
);
   logic                  valid_ff, valid_in;
   falru_pkg::result_type data_ff, data_in;

   always_comb begin
      out_free = !valid_ff || rsp_bus.ready;
      valid_in = valid_ff;
      data_in  = data_ff;
      if (res_we) begin
         valid_in = 1'b1;
         data_in  = res;
      end else if (rsp_bus.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_bus.valid       = valid_ff;
   assign rsp_bus.hit         = data_ff.hit;
   assign rsp_bus.line_index  = data_ff.line_index;
   assign rsp_bus.fill_needed = data_ff.fill_needed;
   assign rsp_bus.line_base   = data_ff.line_base;
   assign rsp_bus.byte_offset = data_ff.byte_offset;
   assign rsp_bus.last        = data_ff.last;
endmodule
`default_nettype wire

/* sv/falru_scan.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// falru_scan
// Lookup engine: walks the tag and stamp memories one line per cycle,
// finds a hit or the least recently used victim, then writes back the new
// stamp (and tag on a miss). A request that runs past its line gets a
// second access for the next line.
// ----------------------------------------------------------------------------
module falru_scan #(
   parameter int LINES     = falru_pkg::LINES_DEF,
   parameter int ADDR_BITS = falru_pkg::ADDR_BITS_DEF
) (
   input  wire logic                                          clock,
   input  wire logic                                          reset,
   falru_req_if.sink                                          req_bus,
   input  wire logic [falru_pkg::OB_W-1:0]                    ob_eff,
   input  wire logic [((LINES > 1) ? $clog2(LINES) : 1)-1:0]  lines_m1,
   input  wire logic                                          out_free,
   output logic                                               res_we,
   output falru_pkg::result_type                              res
);
   localparam int IDX_W = (LINES > 1) ? $clog2(LINES) : 1;
   localparam int TAG_W = ADDR_BITS - int'(falru_pkg::MIN_OB);
   localparam int SW    = falru_pkg::STAMP_W;
   localparam int BW    = falru_pkg::BOFF_W;

   typedef enum logic [1:0] {S_IDLE, S_START, S_SCAN, S_WRITE} state_type;

   state_type                     state_ff, state_in;
   logic [ADDR_BITS-1:0]          addr_ff, addr_in;
   logic [BW-1:0]                 boff_ff, boff_in;
   logic                          cross_ff, cross_in;
   logic [falru_pkg::OB_W-1:0]    ob_ff, ob_in;
   logic [SW-1:0]                 clk_ff, clk_in;
   logic [SW-1:0]                 min_ff, min_in;
   logic [IDX_W-1:0]              chk_ff, chk_in;
   logic [IDX_W-1:0]              victim_ff, victim_in;
   logic [IDX_W-1:0]              idx_ff, idx_in;
   logic                          hit_ff, hit_in;
   logic [LINES-1:0]              vbit_ff, vbit_in;

   logic [ADDR_BITS-1:0]          acc_addr, size_a, base, next_addr;
   logic [BW-1:0]                 acc_off, mask10;
   logic                          acc_cross;
   logic [TAG_W-1:0]              tag_cur, tag_rd;
   logic [SW-1:0]                 stamp_rd, stamp_eff;
   logic                          is_hit, take;
   logic [IDX_W-1:0]              ram_raddr;
   logic                          stamp_we, tag_we;

   // Request decode uses the live offset setting; the user keeps it stable while busy, the block does not enforce it.
   always_comb begin
      acc_addr  = ADDR_BITS'(req_bus.read_address);
      mask10    = BW'((11'd1 << ob_eff) - 11'd1);
      acc_off   = BW'(acc_addr) & mask10;
      acc_cross = ({1'b0, acc_off} + 11'(falru_pkg::READ_BYTES)) > (11'd1 << ob_eff);
   end

   always_comb begin
      size_a    = ADDR_BITS'(1) << ob_ff;
      base      = addr_ff & ~(size_a - ADDR_BITS'(1));
      next_addr = base + size_a;
      tag_cur   = TAG_W'(addr_ff >> ob_ff);
      // A line that was never stamped reads as stamp zero, i.e. invalid.
      stamp_eff = vbit_ff[chk_ff] ? stamp_rd : '0;
      is_hit    = (stamp_eff != '0) && (tag_rd == tag_cur);
      take      = (chk_ff == '0) || (min_ff > stamp_eff);
   end

   always_comb begin
      state_in  = state_ff;
      addr_in   = addr_ff;
      boff_in   = boff_ff;
      cross_in  = cross_ff;
      ob_in     = ob_ff;
      clk_in    = clk_ff;
      min_in    = min_ff;
      chk_in    = chk_ff;
      victim_in = victim_ff;
      idx_in    = idx_ff;
      hit_in    = hit_ff;
      vbit_in   = vbit_ff;
      ram_raddr = '0;
      stamp_we  = 1'b0;
      tag_we    = 1'b0;
      res_we    = 1'b0;
      req_bus.ready = (state_ff == S_IDLE);

      res.hit         = hit_ff;
      res.line_index  = falru_pkg::LINE_IDX_W'(idx_ff);
      res.fill_needed = !hit_ff;
      res.line_base   = falru_pkg::LINE_BASE_W'(base);
      res.byte_offset = boff_ff;
      res.last        = !cross_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               addr_in  = acc_addr;
               boff_in  = acc_off;
               cross_in = acc_cross;
               ob_in    = ob_eff;
               clk_in   = clk_ff + 1'b1;
               chk_in   = '0;
               state_in = S_SCAN;
            end
         end
         S_START: begin
            // Second access: the write-back of the first is now committed.
            clk_in   = clk_ff + 1'b1;
            chk_in   = '0;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            ram_raddr = (chk_ff == lines_m1) ? chk_ff : chk_ff + 1'b1;
            if (is_hit) begin
               hit_in   = 1'b1;
               idx_in   = chk_ff;
               state_in = S_WRITE;
            end else begin
               if (take) begin
                  min_in    = stamp_eff;
                  victim_in = chk_ff;
               end
               if (chk_ff == lines_m1) begin
                  hit_in   = 1'b0;
                  idx_in   = take ? chk_ff : victim_ff;
                  state_in = S_WRITE;
               end else begin
                  chk_in = chk_ff + 1'b1;
               end
            end
         end
         S_WRITE: begin
            if (out_free) begin
               stamp_we = 1'b1;
               tag_we   = !hit_ff;
               res_we   = 1'b1;
               vbit_in  = vbit_ff | (LINES'(1) << idx_ff);
               if (cross_ff) begin
                  addr_in  = next_addr;
                  boff_in  = '0;
                  cross_in = 1'b0;
                  state_in = S_START;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         clk_ff   <= '0;
         vbit_ff  <= '0;
      end else begin
         state_ff <= state_in;
         clk_ff   <= clk_in;
         vbit_ff  <= vbit_in;
      end
      addr_ff   <= addr_in;
      boff_ff   <= boff_in;
      cross_ff  <= cross_in;
      ob_ff     <= ob_in;
      min_ff    <= min_in;
      chk_ff    <= chk_in;
      victim_ff <= victim_in;
      idx_ff    <= idx_in;
      hit_ff    <= hit_in;
   end

   falru_ram #(.WIDTH(TAG_W), .DEPTH(LINES)) u_tag_ram (
      .clock (clock),
      .we    (tag_we),
      .waddr (idx_ff),
      .wdata (tag_cur),
      .raddr (ram_raddr),
      .rdata (tag_rd)
   );

   falru_ram #(.WIDTH(SW), .DEPTH(LINES)) u_stamp_ram (
      .clock (clock),
      .we    (stamp_we),
      .waddr (idx_ff),
      .wdata (clk_ff),
      .raddr (ram_raddr),
      .rdata (stamp_rd)
   );

   a_clock_step: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_IDLE && req_bus.valid) || state_ff == S_START)
      |=> (clk_ff == $past(clk_ff) + 1'b1))
      else $error("access clock did not advance on an access");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      res_we |-> out_free)
      else $error("result written while the output register is occupied");

   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (chk_ff <= lines_m1))
      else $error("scan index beyond the active lines");

   a_cross_next: assert property (@(posedge clock) disable iff (reset)
      (res_we && !res.last) |=> (state_ff == S_START))
      else $error("line crossing did not start the second access");

   a_hit_valid: assert property (@(posedge clock) disable iff (reset)
      (res_we && res.hit) |-> vbit_ff[idx_ff])
      else $error("hit reported on a line that was never stamped");
endmodule
`default_nettype wire

/* sv/fully_assoc_lru_cache_directory_unit.sv */
`default_nettype none
// A request is accepted in idle, its active lines are scanned one per cycle
// from the tag and stamp memories, and the result is written back once the
// output register is free. A request that crosses into the next line gets
// a second access and gives two response beats. The first response is
// registered at write-back. Synchronous reset clears the access clock, the
// line valid bits and the settings (32-byte lines, 16 lines); no sweep.
// ----------------------------------------------------------------------------
// fully_assoc_lru_cache_directory_unit
// Fully associative cache directory with LRU replacement: settings,
// lookup engine and output register.
// ----------------------------------------------------------------------------
module fully_assoc_lru_cache_directory_unit #(
   parameter int LINES     = falru_pkg::LINES_DEF,
   parameter int ADDR_BITS = falru_pkg::ADDR_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   falru_req_if.sink                                req_bus,
   falru_rsp_if.source                              rsp_bus,
   input  wire logic                                csr_we,
   input  wire logic [falru_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [falru_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   localparam int IDX_W = (LINES > 1) ? $clog2(LINES) : 1;

   logic [falru_pkg::OB_W-1:0] ob_cfg_ff, ob_cfg_in, ob_eff;
   logic [falru_pkg::AL_W-1:0] lines_cfg_ff, lines_cfg_in;
   logic [31:0]                n_eff;
   logic [IDX_W-1:0]           lines_m1;
   logic                       out_free;
   logic                       res_we;
   falru_pkg::result_type      res;

   always_comb begin
      ob_cfg_in    = ob_cfg_ff;
      lines_cfg_in = lines_cfg_ff;
      if (csr_we) begin
         case (csr_index)
            falru_pkg::CSR_LINE_OFFSET_BITS: ob_cfg_in    = falru_pkg::OB_W'(csr_wdata);
            falru_pkg::CSR_ACTIVE_LINES:     lines_cfg_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ob_cfg_ff    <= falru_pkg::OB_RESET;
         lines_cfg_ff <= falru_pkg::AL_RESET;
      end else begin
         ob_cfg_ff    <= ob_cfg_in;
         lines_cfg_ff <= lines_cfg_in;
      end
   end

   // Out-of-range settings are clamped to the nearest legal value.
   always_comb begin
      if (ob_cfg_ff < falru_pkg::MIN_OB) begin
         ob_eff = falru_pkg::MIN_OB;
      end else if (ob_cfg_ff > falru_pkg::MAX_OB) begin
         ob_eff = falru_pkg::MAX_OB;
      end else begin
         ob_eff = ob_cfg_ff;
      end
      if (lines_cfg_ff == '0) begin
         n_eff = 32'd1;
      end else if (32'(lines_cfg_ff) > 32'(LINES)) begin
         n_eff = 32'(LINES);
      end else begin
         n_eff = 32'(lines_cfg_ff);
      end
      lines_m1 = IDX_W'(n_eff - 32'd1);
   end

   falru_scan #(.LINES(LINES), .ADDR_BITS(ADDR_BITS)) u_scan (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .ob_eff   (ob_eff),
      .lines_m1 (lines_m1),
      .out_free (out_free),
      .res_we   (res_we),
      .res      (res)
   );

   falru_out u_out (
      .clock    (clock),
      .reset    (reset),
      .res_we   (res_we),
      .res      (res),
      .out_free (out_free),
      .rsp_bus  (rsp_bus)
   );
endmodule
`default_nettype wire

/* tb/tb_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the fully associative LRU cache directory. A
// directed table and phases of random reads are sent under several line
// sizes and line counts. Every accepted read is run through a local copy of
// the directory, and each response beat is compared field by field with
// the oldest expected result.
// ----------------------------------------------------------------------------
module tb_top;
   import falru_pkg::*;

   localparam int CYCLE_LIMIT      = 400000;
   localparam int DRAIN_CYCLES     = 2 * LINES_DEF + 8;
   localparam int RANDOM_PER_PHASE = 137;
   localparam int PHASES           = 11;
   localparam int FIXED_PHASES     = 6;
   localparam int DIRECTED_READS   = 23;
   localparam int MAX_REPORTS      = 40;
   localparam int HISTORY          = 32;

   typedef struct {
      logic [31:0] addr;
      logic        typed;
      result_type  first;
      result_type  second;
   } read_row;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   falru_req_if req_bus();
   falru_rsp_if rsp_bus();

   fully_assoc_lru_cache_directory_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Local copy of the directory state and its two settings.
   logic [31:0]        dir_tag   [LINES_DEF];
   logic [STAMP_W-1:0] dir_stamp [LINES_DEF];
   logic [STAMP_W-1:0] access_count;
   logic [OB_W-1:0]    cfg_offset_bits;
   logic [AL_W-1:0]    cfg_lines;

   result_type pending_lookups[$];
   read_row    directed_reads[DIRECTED_READS];

   int cycle_count   = 0;
   int burst_left    = 1;
   int errors        = 0;
   int reads_sent    = 0;
   int beats_checked = 0;
   int hit_beats     = 0;
   int crossings     = 0;

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic int line_bits();
      if (cfg_offset_bits < MIN_OB) return MIN_OB;
      if (cfg_offset_bits > MAX_OB) return MAX_OB;
      return cfg_offset_bits;
   endfunction

   function automatic int lines_in_use();
      if (cfg_lines == '0) return 1;
      if (cfg_lines > LINES_DEF) return LINES_DEF;
      return cfg_lines;
   endfunction

   function automatic result_type lookup_beat(input logic hit, input int idx, input logic fill,
                                              input logic [31:0] base, input int boff,
                                              input logic is_last);
      result_type r;
      r.hit         = hit;
      r.line_index  = LINE_IDX_W'(idx);
      r.fill_needed = fill;
      r.line_base   = base;
      r.byte_offset = BOFF_W'(boff);
      r.last        = is_last;
      return r;
   endfunction

   // One directory access: search, pick the victim on a miss, restamp.
   function automatic result_type dir_access(input logic [31:0] addr,
                                             input logic [BOFF_W-1:0] boff,
                                             input logic is_last);
      int   ob;
      int   n;
      int   victim;
      int   idx;
      logic found;
      logic [31:0] tag;
      ob     = line_bits();
      n      = lines_in_use();
      tag    = addr >> ob;
      victim = 0;
      idx    = 0;
      found  = 1'b0;
      access_count = access_count + 1'b1;
      for (int i = 0; i < n; i++) begin
         if (!found) begin
            if (dir_stamp[i] != '0 && dir_tag[i] == tag) begin
               found = 1'b1;
               idx   = i;
            end else if (dir_stamp[victim] > dir_stamp[i]) begin
               victim = i;
            end
         end
      end
      if (!found) begin
         idx          = victim;
         dir_tag[idx] = tag;
      end
      dir_stamp[idx] = access_count;
      return lookup_beat(found, idx, !found, tag << ob, boff, is_last);
   endfunction

   // A read that runs past the end of its line also touches the next line.
   function automatic int predict_read(input logic [31:0] addr, output result_type first,
                                       output result_type second);
      logic [31:0] size;
      logic [31:0] off;
      size   = 32'd1 << line_bits();
      off    = addr & (size - 1);
      second = '0;
      if (off + READ_BYTES <= size) begin
         first = dir_access(addr, off[BOFF_W-1:0], 1'b1);
         return 1;
      end
      first  = dir_access(addr, off[BOFF_W-1:0], 1'b0);
      second = dir_access((addr & ~(size - 1)) + size, '0, 1'b1);
      return 2;
   endfunction

   // Called just after a rising edge. Holds valid high across a burst.
   task automatic send_read(input logic [31:0] addr, input logic typed,
                            input result_type t_first, input result_type t_second);
      result_type p_first;
      result_type p_second;
      int         n;
      req_bus.valid        <= 1'b1;
      req_bus.read_address <= addr;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      n = predict_read(addr, p_first, p_second);
      if (typed) begin
         p_first  = t_first;
         p_second = t_second;
      end
      pending_lookups.push_back(p_first);
      if (n == 2) pending_lookups.push_back(p_second);
      reads_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(1, 16);
      end
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (pending_lookups.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input int value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      @(posedge clock);
      if (idx == CSR_LINE_OFFSET_BITS) cfg_offset_bits = OB_W'(value);
      else cfg_lines = AL_W'(value);
   endtask

   // Cycle count, timeout and the receiver's stall pattern.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("fully_assoc_lru_cache_directory_unit verification failed");
         $finish;
      end
      case (cycle_count[9:8])
         2'd0: rsp_bus.ready <= 1'b1;
         2'd1: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
         2'd2: rsp_bus.ready <= (cycle_count[1:0] == 2'd0);
         default: rsp_bus.ready <= $urandom_range(0, 1);
      endcase
   end

   always @(posedge clock) begin : rsp_check
      result_type got;
      result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.hit         = rsp_bus.hit;
         got.line_index  = rsp_bus.line_index;
         got.fill_needed = rsp_bus.fill_needed;
         got.line_base   = rsp_bus.line_base;
         got.byte_offset = rsp_bus.byte_offset;
         got.last        = rsp_bus.last;
         beats_checked++;
         if (got.hit) hit_beats++;
         if (!got.last) crossings++;
         if (pending_lookups.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: beat with nothing expected, got %p", $time, got);
         end else begin
            want = pending_lookups.pop_front();
            if (got !== want) begin
               errors++;
               if (errors <= MAX_REPORTS) begin
                  if (got.hit !== want.hit)
                     $display("%0t: hit expected %0b, got %0b", $time, want.hit, got.hit);
                  if (got.line_index !== want.line_index)
                     $display("%0t: line_index expected %0d, got %0d", $time,
                              want.line_index, got.line_index);
                  if (got.fill_needed !== want.fill_needed)
                     $display("%0t: fill_needed expected %0b, got %0b", $time,
                              want.fill_needed, got.fill_needed);
                  if (got.line_base !== want.line_base)
                     $display("%0t: line_base expected %h, got %h", $time,
                              want.line_base, got.line_base);
                  if (got.byte_offset !== want.byte_offset)
                     $display("%0t: byte_offset expected %0d, got %0d", $time,
                              want.byte_offset, got.byte_offset);
                  if (got.last !== want.last)
                     $display("%0t: last expected %0b, got %0b", $time, want.last, got.last);
               end
            end
         end
      end
   end

   initial begin
      int          fixed_ob    [FIXED_PHASES];
      int          fixed_lines [FIXED_PHASES];
      logic [31:0] recent_addr [HISTORY];
      int          recent_count;
      int          recent_wr;
      int          ob_value;
      int          lines_value;
      int          choice;
      logic [31:0] size;
      logic [31:0] region_base;
      logic [31:0] addr;

      reset                = 1'b1;
      csr_we               = 1'b0;
      csr_index            = CSR_LINE_OFFSET_BITS;
      csr_wdata            = '0;
      req_bus.valid        = 1'b0;
      req_bus.read_address = '0;
      rsp_bus.ready        = 1'b0;
      for (int i = 0; i < LINES_DEF; i++) begin
         dir_tag[i]   = '0;
         dir_stamp[i] = '0;
      end
      access_count    = '0;
      cfg_offset_bits = OB_RESET;
      cfg_lines       = AL_RESET;
      recent_count    = 0;
      recent_wr       = 0;

      // Extremes first: line size outside the legal range in both directions,
      // a single line, and line counts outside their range.
      fixed_ob    = '{10, 0, 31, 5, 4, 11};
      fixed_lines = '{1, 0, 31, 16, 17, 2};

      // After reset: 32-byte lines, all 16 lines empty.
      directed_reads[0]  = '{32'h0000_0000, 1'b1,
                             lookup_beat(0, 0, 1, 32'h0000_0000, 0, 1), '0};
      directed_reads[1]  = '{32'h0000_0004, 1'b1,
                             lookup_beat(1, 0, 0, 32'h0000_0000, 4, 1), '0};
      // Crosses into the second line, which lands in the first empty slot.
      directed_reads[2]  = '{32'h0000_001C, 1'b1,
                             lookup_beat(1, 0, 0, 32'h0000_0000, 28, 0),
                             lookup_beat(0, 1, 1, 32'h0000_0020, 0, 1)};
      directed_reads[3]  = '{32'h0000_0018, 1'b1,
                             lookup_beat(1, 0, 0, 32'h0000_0000, 24, 1), '0};
      // Top of the address space: the next line wraps around to zero.
      directed_reads[4]  = '{32'hFFFF_FFFF, 1'b1,
                             lookup_beat(0, 2, 1, 32'hFFFF_FFE0, 31, 0),
                             lookup_beat(1, 0, 0, 32'h0000_0000, 0, 1)};
      directed_reads[5]  = '{32'hFFFF_FFF8, 1'b1,
                             lookup_beat(1, 2, 0, 32'hFFFF_FFE0, 24, 1), '0};
      // Fill the remaining lines, then force an LRU eviction.
      directed_reads[6]  = '{32'h0000_0040, 1'b0, '0, '0};
      directed_reads[7]  = '{32'h0000_0060, 1'b0, '0, '0};
      directed_reads[8]  = '{32'h0000_0080, 1'b0, '0, '0};
      directed_reads[9]  = '{32'h0000_00A0, 1'b0, '0, '0};
      directed_reads[10] = '{32'h0000_00C0, 1'b0, '0, '0};
      directed_reads[11] = '{32'h0000_00E0, 1'b0, '0, '0};
      directed_reads[12] = '{32'h0000_0100, 1'b0, '0, '0};
      directed_reads[13] = '{32'h0000_0120, 1'b0, '0, '0};
      directed_reads[14] = '{32'h0000_0140, 1'b0, '0, '0};
      directed_reads[15] = '{32'h0000_0160, 1'b0, '0, '0};
      directed_reads[16] = '{32'h0000_0180, 1'b0, '0, '0};
      directed_reads[17] = '{32'h0000_01A0, 1'b0, '0, '0};
      directed_reads[18] = '{32'h0000_01C0, 1'b0, '0, '0};
      directed_reads[19] = '{32'h0000_01E0, 1'b0, '0, '0};
      directed_reads[20] = '{32'h0000_003F, 1'b0, '0, '0};
      directed_reads[21] = '{32'hAAAA_AAAA, 1'b0, '0, '0};
      directed_reads[22] = '{32'h5555_5555, 1'b0, '0, '0};

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_reads[i])
         send_read(directed_reads[i].addr, directed_reads[i].typed,
                   directed_reads[i].first, directed_reads[i].second);

      // Phase zero keeps the reset settings. Stored lines survive every
      // change of settings, so later phases start from a warm directory.
      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase > 0) begin
            wait_idle();
            if (phase <= FIXED_PHASES) begin
               ob_value    = fixed_ob[phase-1];
               lines_value = fixed_lines[phase-1];
            end else begin
               ob_value    = $urandom_range(5, 10);
               lines_value = $urandom_range(1, 16);
            end
            write_csr(CSR_LINE_OFFSET_BITS, ob_value);
            write_csr(CSR_ACTIVE_LINES, lines_value);
            csr_we <= 1'b0;
         end
         region_base = ($urandom_range(0, 3) == 0) ? 32'hFFFF_C000
                                                   : ($urandom() & 32'hFFFF_0000);
         repeat (RANDOM_PER_PHASE) begin
            size   = 32'd1 << line_bits();
            choice = $urandom_range(0, 99);
            // Mostly reuse of recent lines and a small working set a bit larger
            // than the cache, so that hits and evictions both stay frequent.
            if (choice < 40 && recent_count > 0) begin
               addr = recent_addr[$urandom_range(0, recent_count - 1)];
               addr = (addr & ~(size - 1)) | ($urandom() & (size - 1));
            end else if (choice < 70) begin
               addr = region_base + $urandom_range(0, (lines_in_use() + 3) * size - 1);
            end else if (choice < 85) begin
               addr = region_base + size * $urandom_range(0, lines_in_use() + 3)
                      + size - $urandom_range(1, 7);
            end else begin
               addr = $urandom();
            end
            recent_addr[recent_wr] = addr;
            recent_wr = (recent_wr + 1) % HISTORY;
            if (recent_count < HISTORY) recent_count++;
            send_read(addr, 1'b0, '0, '0);
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d reads (%0d from the directed table) under %0d settings.",
               reads_sent, DIRECTED_READS, PHASES);
      $display("Checked %0d beats: %0d hits, %0d fills, %0d line crossings, %0d errors.",
               beats_checked, hit_beats, beats_checked - hit_beats, crossings, errors);
      if (errors == 0)
         $display("fully_assoc_lru_cache_directory_unit verification clean");
      else
         $display("fully_assoc_lru_cache_directory_unit verification failed");
      $finish;
   end

endmodule
`default_nettype wire

/* filelist.f */
sv/falru_pkg.sv
sv/falru_req_if.sv
sv/falru_rsp_if.sv
sv/falru_ram.sv
sv/falru_out.sv
sv/falru_scan.sv
sv/fully_assoc_lru_cache_directory_unit.sv
tb/tb_top.sv
